>>> hw/rtl/ppli_pkg.sv
// Shared types, codes and constants of the periodic piecewise linear interpolator.
package ppli_pkg;

   // Default sizes
   localparam int MAX_POINTS_DEF = 64;
   localparam int FRAC_BITS_DEF  = 16;

   // Iteration counts of the shared shift/add and divide unit
   localparam logic [6:0] MOD_STEPS = 7'd32;
   localparam logic [6:0] MUL_STEPS = 7'd33;
   localparam logic [6:0] DIV_STEPS = 7'd66;

   // Item kinds
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Derivative orders
   localparam logic [1:0] ORD_VALUE = 2'd0;
   localparam logic [1:0] ORD_SLOPE = 2'd1;
   localparam logic [1:0] ORD_CURVE = 2'd2;
   localparam logic [1:0] ORD_BAD   = 2'd3;

   // Status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_BEFORE = 2'd1;
   localparam logic [1:0] STATUS_AFTER  = 2'd2;
   localparam logic [1:0] STATUS_ORDER  = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_POINT_COUNT  = 2'd0;
   localparam logic [1:0] CSR_PERIODIC     = 2'd1;
   localparam logic [1:0] CSR_WINDOW_START = 2'd2;
   localparam logic [1:0] CSR_WINDOW_END   = 2'd3;

   typedef struct packed {
      logic              action;
      logic [5:0]        point_index;
      logic signed [31:0] point_time;
      logic signed [31:0] point_value;
      logic signed [31:0] query_time;
      logic [1:0]        derivative_order;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic              in_range;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic [6:0]         point_count;
      logic               periodic_enable;
      logic signed [31:0] window_start;
      logic signed [31:0] window_end;
   } cfg_type;

   // Datapath commands issued by the controller states; the remainder and divide states share OP_DIV_STEP
   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_RD_FIRST,
      OP_RD_LAST,
      OP_LATCH_LAST,
      OP_WRAP,
      OP_DIV_STEP,
      OP_MOD_FIN,
      OP_RANGE,
      OP_SRCH_RD,
      OP_SRCH_CMP,
      OP_FETCH,
      OP_FETCH_A,
      OP_FETCH_B,
      OP_SETUP,
      OP_MUL_STEP,
      OP_DIV_INIT,
      OP_FINISH,
      OP_DELIVER
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic wrap_go;
      logic t_lt_t0;
      logic t_eq_t0;
      logic found;
      logic last_idx;
      logic step_last;
      logic order_skip;
      logic dt_zero;
      logic rsp_free;
   } stat_type;

endpackage

>>> hw/rtl/ppli_ctrl.sv
// Sequencer of the interpolator: walks one query through wrap, search and arithmetic.
module ppli_ctrl import ppli_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_stall,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [18:0] {
      S_IDLE   = 19'h00001,
      S_RD0    = 19'h00002,
      S_RDL    = 19'h00004,
      S_CHK    = 19'h00008,
      S_WRAP   = 19'h00010,
      S_MOD    = 19'h00020,
      S_MODFIN = 19'h00040,
      S_RANGE  = 19'h00080,
      S_SRD    = 19'h00100,
      S_SCMP   = 19'h00200,
      S_FETCH  = 19'h00400,
      S_FETA   = 19'h00800,
      S_FETB   = 19'h01000,
      S_SETUP  = 19'h02000,
      S_MUL    = 19'h04000,
      S_DINIT  = 19'h08000,
      S_DIV    = 19'h10000,
      S_FIN    = 19'h20000,
      S_DONE   = 19'h40000
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   // Next state and command
   always_comb begin
      state_in = state_ff;
      cmd.op   = OP_NONE;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = OP_ACCEPT;
               if (stat.is_query) state_in = S_RD0;
            end
         end
         S_RD0: begin
            cmd.op   = OP_RD_FIRST;
            state_in = S_RDL;
         end
         S_RDL: begin
            cmd.op   = OP_RD_LAST;
            state_in = S_CHK;
         end
         S_CHK: begin
            cmd.op   = OP_LATCH_LAST;
            state_in = S_WRAP;
         end
         S_WRAP: begin
            cmd.op   = OP_WRAP;
            state_in = stat.wrap_go ? S_MOD : S_RANGE;
         end
         S_MOD: begin
            cmd.op = OP_DIV_STEP;
            if (stat.step_last) state_in = S_MODFIN;
         end
         S_MODFIN: begin
            cmd.op   = OP_MOD_FIN;
            state_in = S_RANGE;
         end
         S_RANGE: begin
            cmd.op = OP_RANGE;
            if (stat.t_lt_t0)      state_in = S_DONE;
            else if (stat.t_eq_t0) state_in = S_FETCH;
            else                   state_in = S_SRD;
         end
         S_SRD: begin
            cmd.op   = OP_SRCH_RD;
            state_in = S_SCMP;
         end
         S_SCMP: begin
            cmd.op = OP_SRCH_CMP;
            if (stat.found)         state_in = S_FETCH;
            else if (stat.last_idx) state_in = S_DONE;
            else                    state_in = S_SRD;
         end
         S_FETCH: begin
            cmd.op   = OP_FETCH;
            state_in = stat.order_skip ? S_DONE : S_FETA;
         end
         S_FETA: begin
            cmd.op   = OP_FETCH_A;
            state_in = S_FETB;
         end
         S_FETB: begin
            cmd.op   = OP_FETCH_B;
            state_in = S_SETUP;
         end
         S_SETUP: begin
            cmd.op   = OP_SETUP;
            state_in = stat.dt_zero ? S_DONE : S_MUL;
         end
         S_MUL: begin
            cmd.op = OP_MUL_STEP;
            if (stat.step_last) state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.op   = OP_DIV_INIT;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV_STEP;
            if (stat.step_last) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.op   = OP_FINISH;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.rsp_free) begin
               cmd.op   = OP_DELIVER;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

>>> hw/rtl/ppli_dp.sv
// Datapath of the interpolator: breakpoint tables, search, shared shift/add-divide unit.
module ppli_dp import ppli_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  req_type  req_data,
   input  cmd_type  cmd,
   output stat_type stat,
   output logic     rsp_valid,
   input  logic     rsp_stall,
   output rsp_type  rsp_data
);

   localparam int AW = $clog2(MAX_POINTS);

   // Breakpoint tables
   logic signed [31:0] time_mem  [MAX_POINTS];
   logic signed [31:0] value_mem [MAX_POINTS];
   logic [AW-1:0]      raddr;
   logic signed [31:0] rd_t_ff, rd_v_ff;

   // Query state
   logic signed [31:0] t_ff, t0_ff, tl_ff, ta_ff, va_ff, tb_ff, vb_ff;
   logic [1:0]         order_ff;
   logic [AW-1:0]      idx_ff, seg_ff, nm1;
   logic [1:0]         status_ff;
   logic               inr_ff, neg_ff;
   logic signed [31:0] res_ff;

   // Shared unit
   logic [33:0] rem_ff, hi_ff;
   logic [32:0] dvsr_ff, mcand_ff, lo_ff;
   logic [65:0] dq_ff;
   logic [6:0]  cnt_ff, last_ff;

   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   // Last slot in use, count clamped to the table
   always_comb begin
      if (cfg.point_count < 7'd2)
         nm1 = AW'(1);
      else if (32'(cfg.point_count) > MAX_POINTS)
         nm1 = AW'(MAX_POINTS - 1);
      else
         nm1 = AW'(cfg.point_count - 7'd1);
   end

   // Table read address
   always_comb begin
      case (cmd.op)
         OP_RD_LAST: raddr = nm1;
         OP_SRCH_RD: raddr = idx_ff;
         OP_FETCH:   raddr = seg_ff - AW'(1);
         OP_FETCH_A: raddr = seg_ff;
         default:    raddr = '0;
      endcase
   end

   logic wr_en;
   assign wr_en = (cmd.op == OP_ACCEPT) && (req_data.action == ACT_WRITE)
                  && (32'(req_data.point_index) < MAX_POINTS);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         time_mem[AW'(req_data.point_index)]  <= req_data.point_time;
         value_mem[AW'(req_data.point_index)] <= req_data.point_value;
      end
      rd_t_ff <= time_mem[raddr];
      rd_v_ff <= value_mem[raddr];
   end

   // Wrap arithmetic
   logic signed [32:0] span;
   logic [32:0]        span_mag;
   logic [31:0]        t_mag;
   assign span     = 33'(tl_ff) - 33'(t0_ff);
   assign span_mag = span[32] ? 33'(-span) : 33'(span);
   assign t_mag    = t_ff[31] ? 32'(~t_ff + 32'sd1) : 32'(t_ff);

   // Segment arithmetic
   logic signed [32:0] dv, dt, dd;
   logic [32:0]        dv_mag, dt_mag, dd_mag;
   assign dv     = 33'(vb_ff) - 33'(va_ff);
   assign dt     = 33'(tb_ff) - 33'(ta_ff);
   assign dd     = 33'(t_ff) - 33'(ta_ff);
   assign dv_mag = dv[32] ? 33'(-dv) : 33'(dv);
   assign dt_mag = dt[32] ? 33'(-dt) : 33'(dt);
   assign dd_mag = dd[32] ? 33'(-dd) : 33'(dd);

   // One restoring divide step
   logic [33:0] rem_sh, rem_sub;
   logic        ge;
   assign rem_sh  = {rem_ff[32:0], dq_ff[65]};
   assign ge      = rem_sh >= {1'b0, dvsr_ff};
   assign rem_sub = rem_sh - {1'b0, dvsr_ff};

   // One shift/add multiply step
   logic [33:0] madd;
   assign madd = lo_ff[0] ? (hi_ff + {1'b0, mcand_ff}) : hi_ff;

   // Final combine and saturation
   logic [40:0]        qcap;
   logic signed [42:0] base, res_wide;
   logic signed [31:0] res_sat;
   always_comb begin
      qcap     = (dq_ff[65:40] != '0) ? {1'b1, 40'd0} : dq_ff[40:0];
      base     = (order_ff == ORD_VALUE) ? 43'(va_ff) : 43'sd0;
      res_wide = neg_ff ? (base - $signed({2'b00, qcap})) : (base + $signed({2'b00, qcap}));
      if (res_wide > 43'sd2147483647)       res_sat = 32'sh7fffffff;
      else if (res_wide < -43'sd2147483648) res_sat = 32'sh80000000;
      else                                  res_sat = 32'(res_wide);
   end

   // Status to the controller
   always_comb begin
      stat.is_query   = (req_data.action == ACT_QUERY);
      stat.wrap_go    = cfg.periodic_enable && (t_ff >= cfg.window_start)
                        && (t_ff <= cfg.window_end) && (span != '0);
      stat.t_lt_t0    = t_ff < t0_ff;
      stat.t_eq_t0    = t_ff == t0_ff;
      stat.found      = rd_t_ff >= t_ff;
      stat.last_idx   = idx_ff == nm1;
      stat.step_last  = cnt_ff == last_ff;
      stat.order_skip = (order_ff == ORD_BAD) || (order_ff == ORD_CURVE);
      stat.dt_zero    = dt == '0;
      stat.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Query registers
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_ACCEPT: begin
            t_ff      <= req_data.query_time;
            order_ff  <= req_data.derivative_order;
            status_ff <= STATUS_OK;
            res_ff    <= '0;
         end
         OP_RD_LAST:    t0_ff <= rd_t_ff;
         OP_LATCH_LAST: tl_ff <= rd_t_ff;
         OP_WRAP: begin
            if (stat.wrap_go) begin
               dvsr_ff <= span_mag;
               dq_ff   <= {t_mag, 34'd0};
               rem_ff  <= '0;
               cnt_ff  <= '0;
               last_ff <= MOD_STEPS - 7'd1;
            end
         end
         OP_DIV_STEP: begin
            rem_ff <= ge ? rem_sub : rem_sh;
            dq_ff  <= {dq_ff[64:0], ge};
            cnt_ff <= cnt_ff + 7'd1;
         end
         OP_MOD_FIN: begin
            t_ff <= t_ff[31] ? -$signed(rem_ff[31:0]) : $signed(rem_ff[31:0]);
         end
         OP_RANGE: begin
            inr_ff <= (t_ff >= t0_ff) && (t_ff <= tl_ff);
            idx_ff <= AW'(1);
            seg_ff <= AW'(1);
            if (t_ff < t0_ff) status_ff <= STATUS_BEFORE;
         end
         OP_SRCH_CMP: begin
            if (stat.found)         seg_ff    <= idx_ff;
            else if (stat.last_idx) status_ff <= STATUS_AFTER;
            else                    idx_ff    <= idx_ff + AW'(1);
         end
         OP_FETCH: begin
            if (order_ff == ORD_BAD) status_ff <= STATUS_ORDER;
         end
         OP_FETCH_A: begin
            ta_ff <= rd_t_ff;
            va_ff <= rd_v_ff;
         end
         OP_FETCH_B: begin
            tb_ff <= rd_t_ff;
            vb_ff <= rd_v_ff;
         end
         OP_SETUP: begin
            if (dt == '0) begin
               res_ff <= (order_ff == ORD_VALUE) ? va_ff : 32'sd0;
            end else begin
               mcand_ff <= dv_mag;
               lo_ff    <= (order_ff == ORD_VALUE) ? dd_mag : (33'd1 << FRAC_BITS);
               hi_ff    <= '0;
               dvsr_ff  <= dt_mag;
               neg_ff   <= (order_ff == ORD_VALUE) ? (dv[32] ^ dd[32] ^ dt[32])
                                                   : (dv[32] ^ dt[32]);
               cnt_ff   <= '0;
               last_ff  <= MUL_STEPS - 7'd1;
            end
         end
         OP_MUL_STEP: begin
            hi_ff  <= {1'b0, madd[33:1]};
            lo_ff  <= {madd[0], lo_ff[32:1]};
            cnt_ff <= cnt_ff + 7'd1;
         end
         OP_DIV_INIT: begin
            dq_ff   <= {hi_ff[32:0], lo_ff};
            rem_ff  <= '0;
            cnt_ff  <= '0;
            last_ff <= DIV_STEPS - 7'd1;
         end
         OP_FINISH: res_ff <= res_sat;
         default: begin
         end
      endcase
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_DELIVER) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.op == OP_DELIVER) begin
         rsp_ff.result_value <= res_ff;
         rsp_ff.in_range     <= inr_ff;
         rsp_ff.status       <= status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/periodic_piecewise_linear_interp.sv
// Top level of the periodic piecewise linear interpolator with its register file.
//
// Usage: req_ carries items. A write item (action 0) stores one breakpoint
// without raising req_stall; it gives no result. A query item (action 1) gives
// one result on rsp_ with the value, slope or zero, an in-range flag and a status
// code. The time a query takes is set by the shared one-bit-a-cycle unit
// (32 remainder steps for the wrap, 33 multiply steps, 66 divide steps) and the
// linear search, which reads one table entry at a time through the single table
// read port. Queries are handled one at a time.
// Each transfer takes place when valid is high and stall is low. req_stall is
// high while a query is in flight. The result sits in an output register; a
// stalled receiver holds it, and the next item can already be taken meanwhile.
// csr_ writes registers (point count, periodic enable, window start, window
// end) and must be used only while idle. Reset is synchronous, active high; it
// returns the registers to their defaults and drops rsp_valid. The tables are
// not cleared: breakpoints must be written before they are queried.
module periodic_piecewise_linear_interp import ppli_pkg::*; #(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   cfg_type  cfg_ff;
   cmd_type  cmd;
   stat_type stat;

   // Register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.point_count     <= 7'd2;
         cfg_ff.periodic_enable <= 1'b0;
         cfg_ff.window_start    <= '0;
         cfg_ff.window_end      <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_POINT_COUNT:  cfg_ff.point_count     <= csr_data[6:0];
            CSR_PERIODIC:     cfg_ff.periodic_enable <= csr_data[0];
            CSR_WINDOW_START: cfg_ff.window_start    <= $signed(csr_data);
            CSR_WINDOW_END:   cfg_ff.window_end      <= $signed(csr_data);
            default: begin
            end
         endcase
      end
   end

   ppli_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   ppli_dp #(
      .MAX_POINTS (MAX_POINTS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A query transfer closes the input until its result is out
   a_query_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.action == ACT_QUERY) |=> req_stall)
      else $error("input open right after a query transfer");

   // Any error code comes with a zero result
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != STATUS_OK) |-> (rsp_data.result_value == 0))
      else $error("nonzero result with error status");

   // Range errors imply an out-of-range time
   a_range_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.status == STATUS_BEFORE || rsp_data.status == STATUS_AFTER))
      |-> !rsp_data.in_range)
      else $error("in_range set with range error");

endmodule

>>> tb/ppli_checker.sv
// Checker for the interpolator: predicts each query answer and compares results.
`timescale 1ns / 1ps

module ppli_checker import ppli_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data,
   output int          pending,
   output int          errors
);

   localparam longint unsigned QUOT_CAP = 64'd1 << 40;

   // Shadow of the breakpoint tables and registers
   logic signed [31:0] bp_time [64];
   logic signed [31:0] bp_value [64];
   logic [6:0]         point_count;
   logic               periodic_on;
   logic signed [31:0] win_lo;
   logic signed [31:0] win_hi;

   rsp_type answers [$];

   // floor(a*b/d) on magnitudes, capped like the datapath
   function automatic longint unsigned scaled_quot(longint unsigned a, longint unsigned b,
                                                   longint unsigned d);
      logic [127:0] prod;
      logic [127:0] q;
      prod = 128'(a) * 128'(b);
      q = prod / 128'(d);
      if (q >= 128'(QUOT_CAP))
         return QUOT_CAP;
      return q[63:0];
   endfunction

   function automatic longint unsigned mag(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic rsp_type interpolate(req_type q);
      rsp_type r;
      int n;
      int seg;
      longint t, t0, tl, span, res, va, dv, ta, dt, d;
      longint unsigned rem, quot;
      logic neg;
      n = (point_count < 2) ? 2 : (point_count > 64) ? 64 : point_count;
      t = q.query_time;
      t0 = bp_time[0];
      tl = bp_time[n-1];
      res = 0;
      seg = 0;
      r.status = STATUS_OK;

      // periodic wrap inside the window
      if (periodic_on && t >= win_lo && t <= win_hi) begin
         span = tl - t0;
         if (span != 0) begin
            rem = mag(t) % mag(span);
            t = (t < 0) ? -longint'(rem) : longint'(rem);
         end
      end
      r.in_range = (t >= t0 && t <= tl);

      // linear search for the first breakpoint at or past t
      if (t < t0)
         r.status = STATUS_BEFORE;
      else if (t == t0)
         seg = 1;
      else begin
         for (int i = 1; i < n; i++) begin
            if (seg == 0 && longint'(bp_time[i]) >= t)
               seg = i;
         end
         if (seg == 0)
            r.status = STATUS_AFTER;
      end

      if (r.status == STATUS_OK) begin
         if (q.derivative_order == ORD_BAD)
            r.status = STATUS_ORDER;
         else if (q.derivative_order != ORD_CURVE) begin
            va = bp_value[seg-1];
            dv = longint'(bp_value[seg]) - va;
            ta = bp_time[seg-1];
            dt = longint'(bp_time[seg]) - ta;
            d = t - ta;
            if (q.derivative_order == ORD_VALUE) begin
               res = va;
               if (dt != 0) begin
                  quot = scaled_quot(mag(dv), mag(d), mag(dt));
                  neg = ((dv < 0) != (d < 0)) != (dt < 0);
                  res = neg ? va - longint'(quot) : va + longint'(quot);
               end
            end else if (dt != 0) begin
               quot = scaled_quot(mag(dv), 64'd1 << 16, mag(dt));
               res = ((dv < 0) != (dt < 0)) ? -longint'(quot) : longint'(quot);
            end
            // saturate to 32 bits
            if (res > 64'sd2147483647)
               res = 64'sd2147483647;
            else if (res < -64'sd2147483648)
               res = -64'sd2147483648;
         end
      end
      r.result_value = res[31:0];
      return r;
   endfunction

   assign pending = answers.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         point_count <= 7'd2;
         periodic_on <= 1'b0;
         win_lo <= '0;
         win_hi <= '0;
         answers.delete();
         errors <= 0;
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               CSR_POINT_COUNT:  point_count <= csr_data[6:0];
               CSR_PERIODIC:     periodic_on <= csr_data[0];
               CSR_WINDOW_START: win_lo <= csr_data;
               CSR_WINDOW_END:   win_hi <= csr_data;
               default: begin
               end
            endcase
         end
         // result transfer
         if (rsp_valid && !rsp_stall) begin
            if (answers.size() == 0) begin
               errors <= errors + 1;
               if (errors < 10)
                  $display("unexpected result %h", rsp_data);
            end else begin
               want = answers.pop_front();
               if (want !== rsp_data) begin
                  errors <= errors + 1;
                  if (errors < 10)
                     $display("mismatch: exp value %h range %b status %0d, got %h %b %0d",
                              want.result_value, want.in_range, want.status,
                              rsp_data.result_value, rsp_data.in_range, rsp_data.status);
               end
            end
         end
         // request transfer
         if (req_valid && !req_stall) begin
            if (req_data.action == ACT_WRITE) begin
               bp_time[req_data.point_index] <= req_data.point_time;
               bp_value[req_data.point_index] <= req_data.point_value;
            end else
               answers.push_back(interpolate(req_data));
         end
      end
   end

endmodule

>>> tb/testbench.sv
// Top of the interpolator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
   import ppli_pkg::*;

   localparam int SETTLE = 320;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_write;
   logic [1:0]  csr_index;
   logic [31:0] csr_data;
   int          pending;
   int          errors;

   // stimulus-side copy of the table times, used to aim queries
   logic signed [31:0] aim_time [64];
   int                 active_points;
   logic               quiet;
   logic               hold_request;

   periodic_piecewise_linear_interp uut (.*);

   ppli_checker check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_stall <= 1'b1;
            repeat (900) @(posedge clock);
            hold_request = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // one transfer on the request channel, with an optional idle burst first
   task automatic send(req_type item);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_point(int slot, logic signed [31:0] tm, logic signed [31:0] val);
      req_type item;
      item = '{action: ACT_WRITE, point_index: slot[5:0], point_time: tm,
               point_value: val, query_time: $urandom(),
               derivative_order: 2'($urandom())};
      aim_time[slot] = tm;
      send(item);
   endtask

   task automatic query(logic signed [31:0] tm, logic [1:0] order);
      req_type item;
      item = '{action: ACT_QUERY, point_index: 6'($urandom()), point_time: $urandom(),
               point_value: $urandom(), query_time: tm, derivative_order: order};
      send(item);
   endtask

   // wait for every result, then let the block finish any trailing work
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      req_valid <= 1'b0;
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   // refill the first slots: sorted, with repeated times, or unsorted
   task automatic fill_table(int count, int shape, logic signed [31:0] start);
      logic signed [31:0] tm;
      tm = start;
      for (int i = 0; i < count; i++) begin
         if (shape == 2)
            tm = $urandom();
         else if (i > 0)
            tm = tm + ((shape == 1 && $urandom_range(0, 3) == 0) ? 0 :
                       $urandom_range(1, 1 << $urandom_range(0, 24)));
         write_point(i, tm, ($urandom_range(0, 9) == 0) ? $urandom() :
                     $signed($urandom_range(0, 1 << 24)) - (1 << 23));
      end
   endtask

   // query times aimed at breakpoints, the table span, the window or anywhere
   function automatic logic signed [31:0] pick_time(logic signed [31:0] w_lo,
                                                    logic signed [31:0] w_hi);
      logic signed [31:0] lo, hi;
      lo = aim_time[0];
      hi = aim_time[active_points-1];
      case ($urandom_range(0, 5))
         0: return aim_time[$urandom_range(0, active_points-1)] +
                   $signed($urandom_range(0, 4)) - 2;
         1: return $urandom();
         2, 3: return (hi > lo) ? 32'(lo + (($urandom() & 32'h7fffffff) %
                      (longint'(hi) - lo + 3)) - 1) : lo;
         default: return (w_hi > w_lo) ? 32'(w_lo + ((longint'($urandom()) %
                          (longint'(w_hi) - w_lo + 1)))) : w_lo;
      endcase
   endfunction

   initial begin
      logic signed [31:0] w_lo, w_hi;
      int pc, shape;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write = 1'b0;
      csr_index = CSR_POINT_COUNT;
      csr_data = '0;
      quiet = 1'b0;
      hold_request = 1'b0;
      active_points = 2;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: every slot written once, then extremes with the default count
      fill_table(64, 0, 0);
      write_point(0, 32'sh80000000, 32'sh80000000);
      write_point(1, 32'sh7fffffff, 32'sh7fffffff);
      query(32'sh80000000, ORD_VALUE);
      query(32'sh7fffffff, ORD_VALUE);
      query(32'sh00000000, ORD_VALUE);
      query(32'sh00000000, ORD_SLOPE);
      query(32'sh00000000, ORD_CURVE);
      query(32'sh00000000, ORD_BAD);
      // steep segment saturates the slope; zero-length segment gives flat answers
      write_point(0, 32'sh00000000, 32'sh80000000);
      write_point(1, 32'sh00000001, 32'sh7fffffff);
      query(32'sh00000000, ORD_SLOPE);
      query(32'sh00000001, ORD_VALUE);
      query(32'shffffffff, ORD_BAD);
      query(32'sh00000002, ORD_BAD);
      write_point(1, 32'sh00000000, 32'sh00012345);
      query(32'sh00000000, ORD_VALUE);
      query(32'sh00000000, ORD_SLOPE);
      drain();

      // random phases, each with its own register setting
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0: pc = 64;
            1: pc = 2;
            2: pc = 0;
            3: pc = 127;
            default: pc = $urandom_range(2, 64);
         endcase
         active_points = (pc < 2) ? 2 : (pc > 64) ? 64 : pc;
         shape = (phase % 4 == 3) ? 2 : (phase % 3 == 2) ? 1 : 0;
         fill_table(active_points, shape,
                    (phase % 2) ? 0 : $signed($urandom_range(0, 1 << 30)) - (1 << 30));
         case (phase)
            1: begin w_lo = 32'sh80000000; w_hi = 32'sh7fffffff; end
            2: begin w_lo = 0; w_hi = 0; end
            default: begin
               w_lo = $signed($urandom_range(0, 1 << 30)) - (1 << 30);
               w_hi = w_lo + $urandom_range(0, 1 << 30);
            end
         endcase
         write_reg(CSR_POINT_COUNT, 32'(pc));
         write_reg(CSR_PERIODIC, 32'(phase % 3 != 0));
         write_reg(CSR_WINDOW_START, w_lo);
         write_reg(CSR_WINDOW_END, w_hi);
         if (phase == 4)
            hold_request = 1'b1;
         if (phase == 8)
            quiet = 1'b1;
         for (int k = 0; k < 60; k++) begin
            if ($urandom_range(0, 19) == 0)
               write_point($urandom_range(0, active_points-1),
                           aim_time[$urandom_range(0, active_points-1)], $urandom());
            query(pick_time(w_lo, w_hi), 2'($urandom_range(0, 3)));
         end
         drain();
      end

      if (errors == 0 && pending == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
